FILE: rtl/imh_pkg.sv
// indexed min-heap package: sizes, request/response structs, slot entry,
// sequencer states and status codes. no dependencies.
package imh_pkg;

	localparam int CAPACITY = 64;
	localparam int ID_COUNT = 64;
	localparam int KEY_W    = 32;
	localparam int ID_W     = $clog2(ID_COUNT);
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = SLOT_W + 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_PRESENT = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	typedef struct packed {
		op_t              operation;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  item_id;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] top_key;
		logic [ID_W-1:0]  top_id;
		logic [CNT_W-1:0] entry_count;
		logic             is_empty;
		status_t          status;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} slot_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_LOAD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_TOP,
		S_FIN
	} state_t;

endpackage

FILE: rtl/indexed_min_heap.sv
// indexed binary min-heap with an id-to-slot map for removal by id
// depends on imh_pkg (sizes, structs, states, status codes)
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | imh_pkg::req_t (operation, key, item_id)
//  rsp     | out       | rsp_valid/rsp_stall | imh_pkg::rsp_t (top, count, status)
//
// one request at a time; from acceptance to the next acceptance a request goes through
// check and lookup, a read and a compare per heap level walked (sift up, and on a remove
// whose moved entry did not rise, sift down; at most log2(CAPACITY) levels), then a read
// of slot 0. the slot memory has one write port and two registered read ports.
// reset clears the fill count, presence bits and the sequencer; slots need no clearing.
// the next request is taken as soon as the last one is in the response register;
// a stalled response only holds the sequencer at its final step.
module indexed_min_heap (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  imh_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output imh_pkg::rsp_t  rsp
);

	imh_pkg::state_t state_q, state_d;

	// heap slots and id map
	imh_pkg::slot_t               slot_mem [imh_pkg::CAPACITY];
	logic [imh_pkg::SLOT_W-1:0]   map_mem  [imh_pkg::ID_COUNT];
	logic [imh_pkg::ID_COUNT-1:0] valid_q;

	imh_pkg::slot_t             rd_a_q, rd_b_q;
	logic [imh_pkg::SLOT_W-1:0] ra, rb;
	logic [imh_pkg::SLOT_W-1:0] map_rd_q;

	logic                       slot_we;
	logic [imh_pkg::SLOT_W-1:0] slot_wa;
	imh_pkg::slot_t             slot_wd;
	logic                       map_we;
	logic [imh_pkg::ID_W-1:0]   map_wa;
	logic [imh_pkg::SLOT_W-1:0] map_wd;

	logic                       valid_set, valid_clr;

	// request and working registers
	imh_pkg::op_t               op_q;
	logic [imh_pkg::KEY_W-1:0]  key_q;
	logic [imh_pkg::ID_W-1:0]   id_q;
	imh_pkg::slot_t             cur_q, cur_d;
	logic [imh_pkg::SLOT_W-1:0] hole_q, hole_d;
	logic                       moved_q, moved_d;
	logic [imh_pkg::CNT_W-1:0]  fill_q, fill_d;
	imh_pkg::status_t           status_q, status_d;

	logic                       rsp_valid_q;
	imh_pkg::rsp_t              rsp_q, rsp_d;
	logic                       rsp_load;

	logic                         req_acc;
	logic [imh_pkg::CNT_W-1:0]    last_cnt;
	logic [imh_pkg::SLOT_W-1:0]   last_slot;
	logic [imh_pkg::SLOT_W-1:0]   parent;
	logic [imh_pkg::CHILD_W-1:0]  left_c, right_c, fill_ext;
	logic                         right_ok;
	imh_pkg::slot_t               child;
	logic [imh_pkg::SLOT_W-1:0]   child_slot;

	assign req_stall = (state_q != imh_pkg::S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign last_cnt  = fill_q - imh_pkg::CNT_W'(1);
	assign last_slot = last_cnt[imh_pkg::SLOT_W-1:0];
	assign parent    = (hole_q - imh_pkg::SLOT_W'(1)) >> 1;
	assign left_c    = {1'b0, hole_q, 1'b1};
	assign right_c   = left_c + imh_pkg::CHILD_W'(1);
	assign fill_ext  = imh_pkg::CHILD_W'(fill_q);
	assign right_ok  = right_c < fill_ext;

	// pick the smaller child, left on a tie
	always_comb begin
		if (right_ok && (rd_b_q.key < rd_a_q.key)) begin
			child      = rd_b_q;
			child_slot = right_c[imh_pkg::SLOT_W-1:0];
		end else begin
			child      = rd_a_q;
			child_slot = left_c[imh_pkg::SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imh_pkg::S_IDLE;
			fill_q      <= '0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (valid_set) begin
				valid_q[id_q] <= 1'b1;
			end
			if (valid_clr) begin
				valid_q[id_q] <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q     <= req.operation;
			key_q    <= req.key;
			id_q     <= req.item_id;
			map_rd_q <= map_mem[req.item_id];
		end
		cur_q    <= cur_d;
		hole_q   <= hole_d;
		moved_q  <= moved_d;
		status_q <= status_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		rd_a_q <= slot_mem[ra];
		rd_b_q <= slot_mem[rb];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		hole_d    = hole_q;
		moved_d   = moved_q;
		fill_d    = fill_q;
		status_d  = status_q;
		valid_set = 1'b0;
		valid_clr = 1'b0;
		ra        = '0;
		rb        = '0;
		slot_we   = 1'b0;
		slot_wa   = hole_q;
		slot_wd   = cur_q;
		map_we    = 1'b0;
		map_wa    = cur_q.id;
		map_wd    = hole_q;
		rsp_load  = 1'b0;
		rsp_d     = '0;

		unique case (state_q)
			imh_pkg::S_IDLE: begin
				if (req_acc) begin
					state_d = imh_pkg::S_CHECK;
				end
			end
			imh_pkg::S_CHECK: begin
				status_d = imh_pkg::ST_OK;
				moved_d  = 1'b0;
				state_d  = imh_pkg::S_TOP;
				if (op_q == imh_pkg::OP_INSERT) begin
					if (fill_q == imh_pkg::CNT_W'(imh_pkg::CAPACITY)) begin
						status_d = imh_pkg::ST_FULL;
					end else if (valid_q[id_q]) begin
						status_d = imh_pkg::ST_PRESENT;
					end else begin
						cur_d     = '{key: key_q, id: id_q};
						hole_d    = fill_q[imh_pkg::SLOT_W-1:0];
						fill_d    = fill_q + imh_pkg::CNT_W'(1);
						valid_set = 1'b1;
						state_d   = imh_pkg::S_UP_RD;
					end
				end else begin
					if (!valid_q[id_q]) begin
						status_d = imh_pkg::ST_ABSENT;
					end else begin
						valid_clr = 1'b1;
						fill_d    = last_cnt;
						hole_d    = map_rd_q;
						ra        = last_slot;
						// removing the last slot only shrinks the heap
						if (map_rd_q != last_slot) begin
							state_d = imh_pkg::S_LOAD;
						end
					end
				end
			end
			imh_pkg::S_LOAD: begin
				cur_d   = rd_a_q;
				state_d = imh_pkg::S_UP_RD;
			end
			imh_pkg::S_UP_RD: begin
				ra = parent;
				if (hole_q == '0) begin
					if (op_q == imh_pkg::OP_REMOVE && !moved_q) begin
						state_d = imh_pkg::S_DN_RD;
					end else begin
						slot_we = 1'b1;
						map_we  = 1'b1;
						state_d = imh_pkg::S_TOP;
					end
				end else begin
					state_d = imh_pkg::S_UP_CMP;
				end
			end
			imh_pkg::S_UP_CMP: begin
				if (cur_q.key < rd_a_q.key) begin
					// parent drops into the hole
					slot_we = 1'b1;
					slot_wd = rd_a_q;
					map_we  = 1'b1;
					map_wa  = rd_a_q.id;
					hole_d  = parent;
					moved_d = 1'b1;
					state_d = imh_pkg::S_UP_RD;
				end else if (op_q == imh_pkg::OP_REMOVE && !moved_q) begin
					state_d = imh_pkg::S_DN_RD;
				end else begin
					slot_we = 1'b1;
					map_we  = 1'b1;
					state_d = imh_pkg::S_TOP;
				end
			end
			imh_pkg::S_DN_RD: begin
				ra = left_c[imh_pkg::SLOT_W-1:0];
				rb = right_c[imh_pkg::SLOT_W-1:0];
				if (left_c >= fill_ext) begin
					slot_we = 1'b1;
					map_we  = 1'b1;
					state_d = imh_pkg::S_TOP;
				end else begin
					state_d = imh_pkg::S_DN_CMP;
				end
			end
			imh_pkg::S_DN_CMP: begin
				if (child.key < cur_q.key) begin
					// smaller child rises into the hole
					slot_we = 1'b1;
					slot_wd = child;
					map_we  = 1'b1;
					map_wa  = child.id;
					hole_d  = child_slot;
					state_d = imh_pkg::S_DN_RD;
				end else begin
					slot_we = 1'b1;
					map_we  = 1'b1;
					state_d = imh_pkg::S_TOP;
				end
			end
			imh_pkg::S_TOP: begin
				ra      = '0;
				state_d = imh_pkg::S_FIN;
			end
			imh_pkg::S_FIN: begin
				ra = '0;
				rsp_d.entry_count = fill_q;
				rsp_d.status      = status_q;
				rsp_d.is_empty    = (fill_q == '0);
				if (fill_q != '0) begin
					rsp_d.top_key = rd_a_q.key;
					rsp_d.top_id  = rd_a_q.id;
				end
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = imh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = imh_pkg::S_IDLE;
			end
		endcase
	end

	// presence bits track the fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(fill_q))
		else $error("presence bits disagree with fill count");

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= imh_pkg::CNT_W'(imh_pkg::CAPACITY))
		else $error("fill count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == imh_pkg::S_CHECK))
		else $error("accepted request not checked");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
		else $error("empty flag disagrees with count");

	// while sifting, the hole never lies beyond the live slots
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == imh_pkg::S_UP_CMP || state_q == imh_pkg::S_DN_RD)
		|-> (imh_pkg::CNT_W'(hole_q) < fill_q))
		else $error("hole outside the heap");

endmodule

FILE: test/indexed_min_heap_test.sv
`timescale 1ns / 1ps
// testbench for indexed_min_heap: insert and remove-by-id requests with random pacing,
// each response checked against a heap mirror kept in a small scoreboard class.
// depends on imh_pkg and rtl/indexed_min_heap.sv
module indexed_min_heap_test;
	import imh_pkg::*;

	localparam int REQUEST_TARGET = 1150;
	localparam int MAX_REPORTS    = 200;

	// mirror of the heap, the id map and the responses still owed by the block
	class heap_tracker;
		logic [KEY_W-1:0] slot_key [CAPACITY];
		logic [ID_W-1:0]  slot_id  [CAPACITY];
		int               id_slot  [ID_COUNT];
		int               fill;
		int               peak_fill;
		rsp_t             owed_rsp [$];
		int               errors;
		int               checked;
		int               requests;
		int               status_seen [4];

		function new();
			for (int i = 0; i < CAPACITY; i++) begin
				slot_key[i] = '0;
				slot_id[i]  = '0;
			end
			for (int i = 0; i < ID_COUNT; i++)
				id_slot[i] = CAPACITY;
			fill = 0;
			peak_fill = 0;
			errors = 0;
			checked = 0;
			requests = 0;
			for (int i = 0; i < 4; i++)
				status_seen[i] = 0;
		endfunction

		function void swap_slots(int a, int b);
			logic [KEY_W-1:0] k;
			logic [ID_W-1:0]  ia;
			logic [ID_W-1:0]  ib;
			k  = slot_key[a];
			ia = slot_id[a];
			ib = slot_id[b];
			slot_key[a] = slot_key[b];
			slot_key[b] = k;
			slot_id[a] = ib;
			slot_id[b] = ia;
			id_slot[ib] = a;
			id_slot[ia] = b;
		endfunction

		function void sift_up(int s);
			int p;
			while (s > 0) begin
				p = (s - 1) / 2;
				if (!(slot_key[s] < slot_key[p]))
					break;
				swap_slots(p, s);
				s = p;
			end
		endfunction

		function void sift_down(int s);
			int l;
			int c;
			forever begin
				l = 2 * s + 1;
				c = l;
				if (l >= fill)
					break;
				// left child wins ties
				if (l + 1 < fill && slot_key[l + 1] < slot_key[l])
					c = l + 1;
				if (!(slot_key[c] < slot_key[s]))
					break;
				swap_slots(s, c);
				s = c;
			end
		endfunction

		function rsp_t apply_request(req_t r);
			rsp_t    e;
			status_t st;
			int      s;
			int      last;
			st = ST_OK;
			if (r.operation == OP_INSERT) begin
				// full is tested before presence
				if (fill >= CAPACITY)
					st = ST_FULL;
				else if (id_slot[r.item_id] < CAPACITY)
					st = ST_PRESENT;
				else begin
					s = fill;
					slot_key[s] = r.key;
					slot_id[s]  = r.item_id;
					id_slot[r.item_id] = s;
					fill = s + 1;
					sift_up(s);
				end
			end else begin
				s = id_slot[r.item_id];
				if (s >= fill)
					st = ST_ABSENT;
				else begin
					last = fill - 1;
					swap_slots(s, last);
					id_slot[r.item_id] = CAPACITY;
					fill = last;
					// moved entry may need to go either way
					if (s < last) begin
						sift_up(s);
						sift_down(s);
					end
				end
			end
			if (fill > peak_fill)
				peak_fill = fill;
			status_seen[st]++;
			e.top_key     = (fill > 0) ? slot_key[0] : '0;
			e.top_id      = (fill > 0) ? slot_id[0] : '0;
			e.entry_count = CNT_W'(fill);
			e.is_empty    = (fill == 0);
			e.status      = st;
			return e;
		endfunction

		function void note_request(req_t r);
			requests++;
			owed_rsp = {owed_rsp, apply_request(r)};
		endfunction

		function void report(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s", $time, what);
			else if (errors == MAX_REPORTS + 1)
				$display("%0t ns: further mismatches not shown", $time);
		endfunction

		function void compare_field(string field, logic [KEY_W-1:0] want,
				logic [KEY_W-1:0] got);
			if (want !== got)
				report($sformatf("%s mismatch: expected %0h, actual %0h", field, want, got));
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (owed_rsp.size() == 0) begin
				report($sformatf("response with none outstanding: actual %0h", got));
				return;
			end
			e = owed_rsp.pop_front();
			checked++;
			compare_field("top_key", e.top_key, got.top_key);
			compare_field("top_id", KEY_W'(e.top_id), KEY_W'(got.top_id));
			compare_field("entry_count", KEY_W'(e.entry_count), KEY_W'(got.entry_count));
			compare_field("is_empty", KEY_W'(e.is_empty), KEY_W'(got.is_empty));
			compare_field("status", KEY_W'(e.status), KEY_W'(got.status));
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	heap_tracker tracker = new();

	int burst_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;

	indexed_min_heap u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: stall pattern changes every so often
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 200);
		end
		mode_left--;
		stall_phase = (stall_phase + 1) % 9;
		case (stall_mode)
			0: rsp_stall = 1'b0;
			1: rsp_stall = ($urandom_range(0, 3) == 0);
			2: rsp_stall = ($urandom_range(0, 3) != 0);
			default: rsp_stall = (stall_phase < 4);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
	end

	// sender works in bursts; a request holds until taken
	task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
			input logic [ID_W-1:0] id);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				@(negedge clk);
				req_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_valid = 1'b1;
		req.operation = op;
		req.key = key;
		req.item_id = id;
		do
			@(posedge clk);
		while (req_stall);
		tracker.note_request(req);
	endtask

	// an id that is held (or not), starting the search at a random point
	function automatic logic [ID_W-1:0] pick_id(bit want_present);
		int start;
		int id;
		start = $urandom_range(0, ID_COUNT - 1);
		for (int i = 0; i < ID_COUNT; i++) begin
			id = (start + i) % ID_COUNT;
			if ((tracker.id_slot[id] < CAPACITY) == want_present)
				return ID_W'(id);
		end
		return ID_W'(start);
	endfunction

	// narrow keys force ties between parent and children
	function automatic logic [KEY_W-1:0] random_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return KEY_W'($urandom_range(0, 15));
			default: return KEY_W'($urandom());
		endcase
	endfunction

	initial begin
		int insert_bias;
		int seg_left;
		int drain;
		insert_bias = 50;
		seg_left = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty heap, extremes, ties, duplicates, top and last-slot removal
		send_request(OP_REMOVE, 32'h1234_5678, 6'd5);
		send_request(OP_INSERT, '1, 6'd63);
		send_request(OP_INSERT, '0, 6'd0);
		send_request(OP_INSERT, '0, 6'd1);
		send_request(OP_INSERT, 32'd7, 6'd0);
		send_request(OP_INSERT, 32'h5555_5555, 6'd21);
		send_request(OP_INSERT, 32'hAAAA_AAAA, 6'd42);
		send_request(OP_INSERT, 32'h8000_0000, 6'd32);
		send_request(OP_INSERT, 32'd3, 6'd7);
		send_request(OP_REMOVE, '1, 6'd0);
		send_request(OP_REMOVE, '0, tracker.slot_id[tracker.fill - 1]);
		send_request(OP_REMOVE, 32'hFFFF_0000, 6'd63);
		send_request(OP_REMOVE, '0, 6'd0);
		while (tracker.fill > 0)
			send_request(OP_REMOVE, KEY_W'($urandom()), tracker.slot_id[0]);
		send_request(OP_REMOVE, '1, 6'd63);

		// random: segments lean toward filling or draining so full and empty both recur
		while (tracker.requests < REQUEST_TARGET) begin
			if (seg_left == 0) begin
				case ($urandom_range(0, 3))
					0: insert_bias = 92;
					1: insert_bias = 60;
					2: insert_bias = 40;
					default: insert_bias = 12;
				endcase
				seg_left = $urandom_range(20, 120);
			end
			seg_left--;
			if ($urandom_range(0, 99) < insert_bias)
				send_request(OP_INSERT, random_key(), pick_id($urandom_range(0, 99) < 12));
			else
				send_request(OP_REMOVE, KEY_W'($urandom()),
					pick_id($urandom_range(0, 99) >= 12));
		end
		@(negedge clk);
		req_valid = 1'b0;

		drain = 0;
		while (tracker.owed_rsp.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (40) @(posedge clk);
		if (tracker.owed_rsp.size() != 0)
			tracker.report($sformatf("%0d responses never arrived", tracker.owed_rsp.size()));

		$display("ran %0d requests, %0d responses checked, peak count %0d",
			tracker.requests, tracker.checked, tracker.peak_fill);
		$display("status seen: ok %0d, full %0d, present %0d, absent %0d",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
			tracker.status_seen[ST_PRESENT], tracker.status_seen[ST_ABSENT]);
		if (tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("timeout at %0t ns", $time);
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
rtl/imh_pkg.sv
rtl/indexed_min_heap.sv
test/indexed_min_heap_test.sv
